### design/fdmt_pkg.sv
// Shared types, constants and the window helper for the frame-difference motion tracker.
// Depends on nothing; every other design file imports it.
package fdmt_pkg;

  // Default image geometry.
  localparam int FRAME_WIDTH_DEFAULT  = 640;
  localparam int FRAME_HEIGHT_DEFAULT = 480;

  // Width of the signed arithmetic used to place a window around its midpoint.
  localparam int SPAN_W = 15;

  // Packed colour upper bound.
  localparam logic [23:0] TOP_LIMIT = 24'hffffff;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_HALF_SIZE  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_TOP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_LEFT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_BOTTOM = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_RIGHT  = 3'd5;

  // Register reset values.
  localparam logic [7:0]  THRESHOLD_RESET      = 8'd0;
  localparam logic [11:0] MIN_HALF_SIZE_RESET  = 12'd8;
  localparam logic [8:0]  RELEASE_TOP_RESET    = 9'd0;
  localparam logic [9:0]  RELEASE_LEFT_RESET   = 10'd0;
  localparam logic [8:0]  RELEASE_BOTTOM_RESET = 9'd479;
  localparam logic [9:0]  RELEASE_RIGHT_RESET  = 10'd639;

  // One incoming pixel request.
  typedef struct packed {
    logic [8:0] pix_row;
    logic [9:0] pix_col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pix_in_t;

  // One end-of-frame result.
  typedef struct packed {
    logic       motion_found;
    logic [8:0] first_row_out;
    logic [9:0] first_col_out;
    logic [8:0] last_row_out;
    logic [9:0] last_col_out;
    logic [8:0] center_row_out;
    logic [9:0] center_col_out;
    logic [8:0] win_row_start;
    logic [8:0] win_row_end;
    logic [9:0] win_col_start;
    logic [9:0] win_col_end;
  } result_t;

  // Midpoint and clamped window along one axis.
  typedef struct packed {
    logic [9:0]        center;
    logic [SPAN_W-1:0] start;
    logic [SPAN_W-1:0] stop;
  } span_t;

  // Places the next search window around the midpoint of lo and hi. The half-size is
  // half the span, raised to min_half; an inverted span always takes min_half.
  function automatic span_t span_window(logic [9:0] lo, logic [9:0] hi,
                                        logic [11:0] min_half,
                                        logic [SPAN_W-1:0] limit);
    logic [10:0]              sum;
    logic [11:0]              diff;
    logic [10:0]              mag;
    logic [11:0]              size;
    logic signed [SPAN_W-1:0] s;
    logic signed [SPAN_W-1:0] e;
    span_t                    r;
    sum  = {1'b0, lo} + {1'b0, hi};
    diff = {2'b00, hi} - {2'b00, lo};
    mag  = diff[11] ? 11'd0 : diff[11:1];
    size = ({1'b0, mag} > min_half) ? {1'b0, mag} : min_half;
    r.center = sum[10:1];
    s = $signed({{(SPAN_W-10){1'b0}}, r.center}) - $signed({{(SPAN_W-12){1'b0}}, size});
    e = $signed({{(SPAN_W-10){1'b0}}, r.center}) + $signed({{(SPAN_W-12){1'b0}}, size});
    if (s < 0) begin
      s = '0;
    end
    if (s > $signed(limit)) begin
      s = $signed(limit);
    end
    if (e > $signed(limit)) begin
      e = $signed(limit);
    end
    r.start = s;
    r.stop  = e;
    return r;
  endfunction

endpackage

### design/frame_diff_motion_tracker.sv
// Top level of the frame-difference motion tracker: frame store, change test and tracking.
// Depends on fdmt_pkg for payload types, register indexes and the window helper.
//
// Throughput: one pixel request per cycle. The only stall is when a frame result is ready
// while the previous result still waits in the output register.
// A result passes from its frame_end pixel through the store read register, the
// change-test register and then the output register.
// Reset clears control state only; the frame store is undefined until the first frame
// has filled it, and that frame gives no result.
module frame_diff_motion_tracker #(
  parameter int FRAME_WIDTH  = fdmt_pkg::FRAME_WIDTH_DEFAULT,
  parameter int FRAME_HEIGHT = fdmt_pkg::FRAME_HEIGHT_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fdmt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fdmt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             pix_valid,
  output logic                             pix_ready,
  input  fdmt_pkg::pix_in_t                pix,
  output logic                             res_valid,
  input  logic                             res_ready,
  output fdmt_pkg::result_t                res
);
  import fdmt_pkg::*;

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WR    = $clog2(FRAME_HEIGHT + 1);
  localparam int WC    = $clog2(FRAME_WIDTH + 1);

  // Configuration registers.
  logic [7:0]  threshold;
  logic [11:0] min_half_size;
  logic [8:0]  release_top_row;
  logic [9:0]  release_left_col;
  logic [8:0]  release_bottom_row;
  logic [9:0]  release_right_col;

  // Tracking state.
  logic          first_frame;
  logic          seen_change;
  logic [8:0]    first_row;
  logic [9:0]    first_col;
  logic [8:0]    last_row;
  logic [9:0]    last_col;
  logic [WR-1:0] row_lo;
  logic [WR-1:0] row_hi;
  logic [WC-1:0] col_lo;
  logic [WC-1:0] col_hi;

  // Pipeline registers.
  logic        s1_valid;
  pix_in_t     s1_pix;
  logic        s1_inside;
  logic [23:0] rd_data;
  logic        s2_valid;
  pix_in_t     s2_pix;
  logic        s2_inside;
  logic        s2_diff;

  // Frame store.
  logic [23:0] frame_mem [DEPTH];

  logic          advance;
  logic          accept;
  logic          pix_inside;
  logic [AW-1:0] pix_addr;
  logic [23:0]   thr24;
  logic [23:0]   cur_packed;
  logic [23:0]   lo_bound;
  logic [24:0]   hi_sum;
  logic [23:0]   hi_bound;
  logic          s1_diff;
  logic          in_window;
  logic          hit;
  logic          emit;
  logic          retire;
  logic          seen_next;
  logic [8:0]    first_row_next;
  logic [9:0]    first_col_next;
  logic [8:0]    last_row_next;
  logic [9:0]    last_col_next;
  logic [8:0]    fin_first_row;
  logic [9:0]    fin_first_col;
  logic [8:0]    fin_last_row;
  logic [9:0]    fin_last_col;
  span_t         row_span;
  span_t         col_span;
  result_t       res_next;

  // The pipeline moves unless a new result would overwrite one that is still waiting.
  assign advance   = !(s2_valid && s2_pix.frame_end && !first_frame && res_valid && !res_ready);
  assign pix_ready = advance;
  assign accept    = pix_valid && advance;
  assign retire    = advance && s2_valid;
  assign emit      = retire && s2_pix.frame_end && !first_frame;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold          <= THRESHOLD_RESET;
      min_half_size      <= MIN_HALF_SIZE_RESET;
      release_top_row    <= RELEASE_TOP_RESET;
      release_left_col   <= RELEASE_LEFT_RESET;
      release_bottom_row <= RELEASE_BOTTOM_RESET;
      release_right_col  <= RELEASE_RIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:      threshold          <= cfg_data[7:0];
        REG_MIN_HALF_SIZE:  min_half_size      <= cfg_data[11:0];
        REG_RELEASE_TOP:    release_top_row    <= cfg_data[8:0];
        REG_RELEASE_LEFT:   release_left_col   <= cfg_data[9:0];
        REG_RELEASE_BOTTOM: release_bottom_row <= cfg_data[8:0];
        REG_RELEASE_RIGHT:  release_right_col  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Store address; pixels outside the image are neither stored nor tested.
  assign pix_inside = (SPAN_W'(pix.pix_row) < SPAN_W'(FRAME_HEIGHT)) &&
                      (SPAN_W'(pix.pix_col) < SPAN_W'(FRAME_WIDTH));
  assign pix_addr   = AW'(pix.pix_row) * AW'(FRAME_WIDTH) + AW'(pix.pix_col);

  // Read the previous frame's pixel and write the new one in the same request.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= frame_mem[pix_addr];
      if (pix_inside) begin
        frame_mem[pix_addr] <= {pix.red, pix.green, pix.blue};
      end
    end
  end

  // First stage: request registered beside the store read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix    <= pix;
      s1_inside <= pix_inside;
    end
  end

  // Change test: the new value must lie outside the saturated band around the old one.
  assign thr24      = {threshold, threshold, threshold};
  assign cur_packed = {s1_pix.red, s1_pix.green, s1_pix.blue};
  assign lo_bound   = (rd_data > thr24) ? (rd_data - thr24) : 24'd0;
  assign hi_sum     = {1'b0, rd_data} + {1'b0, thr24};
  assign hi_bound   = hi_sum[24] ? TOP_LIMIT : hi_sum[23:0];
  assign s1_diff    = (cur_packed < lo_bound) || (cur_packed > hi_bound);

  // Second stage: request with its change flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_pix    <= s1_pix;
      s2_inside <= s1_inside;
      s2_diff   <= s1_diff;
    end
  end

  // Window membership and first/last changed pixel.
  always_comb begin
    in_window = s2_inside &&
                (SPAN_W'(s2_pix.pix_row) >= SPAN_W'(row_lo)) &&
                (SPAN_W'(s2_pix.pix_row) <  SPAN_W'(row_hi)) &&
                (SPAN_W'(s2_pix.pix_col) >= SPAN_W'(col_lo)) &&
                (SPAN_W'(s2_pix.pix_col) <  SPAN_W'(col_hi));
    hit            = !first_frame && in_window && s2_diff;
    seen_next      = seen_change || hit;
    first_row_next = (hit && !seen_change) ? s2_pix.pix_row : first_row;
    first_col_next = (hit && !seen_change) ? s2_pix.pix_col : first_col;
    last_row_next  = hit ? s2_pix.pix_row : last_row;
    last_col_next  = hit ? s2_pix.pix_col : last_col;
  end

  // The first frame takes its area from the release registers.
  always_comb begin
    fin_first_row = first_frame ? release_top_row    : first_row_next;
    fin_first_col = first_frame ? release_left_col   : first_col_next;
    fin_last_row  = first_frame ? release_bottom_row : last_row_next;
    fin_last_col  = first_frame ? release_right_col  : last_col_next;
    row_span = span_window({1'b0, fin_first_row}, {1'b0, fin_last_row}, min_half_size,
                           SPAN_W'(FRAME_HEIGHT));
    col_span = span_window(fin_first_col, fin_last_col, min_half_size,
                           SPAN_W'(FRAME_WIDTH));
  end

  // Result fields; the window shown is the one this frame was searched in.
  always_comb begin
    res_next.motion_found   = seen_next;
    res_next.first_row_out  = first_row_next;
    res_next.first_col_out  = first_col_next;
    res_next.last_row_out   = last_row_next;
    res_next.last_col_out   = last_col_next;
    res_next.center_row_out = row_span.center[8:0];
    res_next.center_col_out = col_span.center;
    res_next.win_row_start  = 9'(row_lo);
    res_next.win_row_end    = 9'(row_hi);
    res_next.win_col_start  = 10'(col_lo);
    res_next.win_col_end    = 10'(col_hi);
  end

  // Tracking state update as each request leaves the second stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_frame <= 1'b1;
      seen_change <= 1'b0;
      first_row   <= RELEASE_TOP_RESET;
      first_col   <= RELEASE_LEFT_RESET;
      last_row    <= RELEASE_BOTTOM_RESET;
      last_col    <= RELEASE_RIGHT_RESET;
      row_lo      <= '0;
      row_hi      <= '0;
      col_lo      <= '0;
      col_hi      <= '0;
    end else if (retire) begin
      if (s2_pix.frame_end) begin
        first_frame <= 1'b0;
        seen_change <= 1'b0;
        first_row   <= fin_first_row;
        first_col   <= fin_first_col;
        last_row    <= fin_last_row;
        last_col    <= fin_last_col;
        row_lo      <= WR'(row_span.start);
        row_hi      <= WR'(row_span.stop);
        col_lo      <= WC'(col_span.start);
        col_hi      <= WC'(col_span.stop);
      end else begin
        seen_change <= seen_next;
        first_row   <= first_row_next;
        first_col   <= first_col_next;
        last_row    <= last_row_next;
        last_col    <= last_col_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_next;
    end
  end

endmodule

### design/fdmt_checker.sv
// Port-level checks for the frame-difference motion tracker, bound to its top level.
// Depends on fdmt_pkg for the payload types.
module fdmt_checker (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input fdmt_pkg::result_t res
);
  import fdmt_pkg::*;

  logic [9:0]  row_sum;
  logic [10:0] col_sum;

  // Midpoints recomputed from the reported first and last changed pixels.
  assign row_sum = {1'b0, res.first_row_out} + {1'b0, res.last_row_out};
  assign col_sum = {1'b0, res.first_col_out} + {1'b0, res.last_col_out};

  // No result may be pending straight after reset.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A result that is not taken keeps its value.
  assert property (@(posedge clk) disable iff (rst)
                   res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("waiting result changed");

  // The centre always lies midway between the reported first and last pixels.
  assert property (@(posedge clk) disable iff (rst)
                   res_valid |-> res.center_row_out == row_sum[9:1] &&
                                 res.center_col_out == col_sum[10:1])
    else $error("centre does not match first and last pixels");

  // The window start never passes its end on either axis.
  assert property (@(posedge clk) disable iff (rst)
                   res_valid |-> res.win_row_start <= res.win_row_end)
    else $error("row window inverted");

  assert property (@(posedge clk) disable iff (rst)
                   res_valid |-> res.win_col_start <= res.win_col_end)
    else $error("column window inverted");

endmodule

bind frame_diff_motion_tracker fdmt_checker u_fdmt_checker (.*);
